>>> hw/rtl/cau_pkg.sv
`timescale 1ns / 1ps
// Complex arithmetic unit package: widths, codes, request/result and pipeline types.
// Depends on nothing; used by every cau_* module and the top level.
package cau_pkg;

  localparam int unsigned IN_W          = 16;
  localparam int unsigned IN_FRAC       = IN_W / 2;
  localparam int unsigned OUT_W         = 40;
  localparam int unsigned OUT_FRAC      = 16;
  localparam int unsigned PROD_W        = 2 * IN_W;
  localparam int unsigned DEN_W         = PROD_W;
  localparam int unsigned DVD_W         = PROD_W + OUT_FRAC;
  localparam int unsigned SQ_W          = PROD_W + 2 * OUT_FRAC - 2 * IN_FRAC;
  localparam int unsigned ROOT_W        = SQ_W / 2;
  localparam int unsigned SREM_W        = ROOT_W + 2;
  localparam int unsigned CORDIC_STEPS  = 16;
  localparam int unsigned ANG_FRAC      = 24;
  localparam int unsigned ANG_RND       = ANG_FRAC - OUT_FRAC;
  localparam int unsigned CX_W          = PROD_W + 4;
  localparam int unsigned ANG_W         = 34;
  localparam int unsigned CORE_STAGES   = DVD_W;
  localparam int          HALF_TURN_DEG = 180;

  localparam logic signed [ANG_W-1:0] ANG_90   = ANG_W'(HALF_TURN_DEG / 2) << ANG_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_180  = ANG_W'(HALF_TURN_DEG) << ANG_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(1) << (ANG_RND - 1);
  localparam logic signed [OUT_W-1:0] OUT_180  = OUT_W'(HALF_TURN_DEG) << OUT_FRAC;
  localparam logic signed [OUT_W-1:0] OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [DVD_W-1:0]        Q_POS_LIM = DVD_W'(OUT_MAX);

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MAG   = 3'd4,
    OP_ANGLE = 3'd5,
    OP_EQUAL = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_SAT     = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [IN_W-1:0]  a_re;
    logic signed [IN_W-1:0]  a_im;
    logic signed [IN_W-1:0]  b_re;
    logic signed [IN_W-1:0]  b_im;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] res_re;
    logic signed [OUT_W-1:0] res_im;
    logic                    is_equal;
    logic [1:0]              status;
  } res_t;

  typedef struct packed {
    op_e                      op;
    logic signed [IN_W-1:0]   ar;
    logic signed [IN_W-1:0]   ai;
    logic signed [IN_W-1:0]   br;
    logic signed [IN_W-1:0]   bi;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] p_ri;
    logic signed [PROD_W-1:0] p_bbr;
    logic signed [PROD_W-1:0] p_bbi;
    logic signed [PROD_W-1:0] p_aar;
    logic signed [PROD_W-1:0] p_aai;
  } prod_t;

  typedef struct packed {
    op_e                     op;
    logic                    eq;
    logic signed [OUT_W-1:0] simple_re;
    logic signed [OUT_W-1:0] simple_im;
    logic                    div_zero;
    logic                    neg_re;
    logic                    neg_im;
    logic [DEN_W-1:0]        den;
    logic [DEN_W-1:0]        rem_re;
    logic [DEN_W-1:0]        rem_im;
    logic [DVD_W-1:0]        dvd_re;
    logic [DVD_W-1:0]        dvd_im;
    logic [DVD_W-1:0]        q_re;
    logic [DVD_W-1:0]        q_im;
    logic [SQ_W-1:0]         rad;
    logic [SREM_W-1:0]       srem;
    logic [ROOT_W-1:0]       root;
    logic signed [CX_W-1:0]  cx;
    logic signed [CX_W-1:0]  cy;
    logic signed [ANG_W-1:0] ang;
    logic                    ang_zero;
    logic                    ang_neg;
  } core_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sd754974720;
      5'd1:    v = 34'sd445687602;
      5'd2:    v = 34'sd235489088;
      5'd3:    v = 34'sd119537938;
      5'd4:    v = 34'sd60000934;
      5'd5:    v = 34'sd30029717;
      5'd6:    v = 34'sd15018523;
      5'd7:    v = 34'sd7509720;
      5'd8:    v = 34'sd3754917;
      5'd9:    v = 34'sd1877466;
      5'd10:   v = 34'sd938734;
      5'd11:   v = 34'sd469367;
      5'd12:   v = 34'sd234684;
      5'd13:   v = 34'sd117342;
      5'd14:   v = 34'sd58671;
      5'd15:   v = 34'sd29335;
      5'd16:   v = 34'sd14668;
      5'd17:   v = 34'sd7334;
      5'd18:   v = 34'sd3667;
      5'd19:   v = 34'sd1833;
      5'd20:   v = 34'sd917;
      5'd21:   v = 34'sd458;
      5'd22:   v = 34'sd229;
      5'd23:   v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/cau_front.sv
`timescale 1ns / 1ps
// Front end: operand products, then sums and set-up of divider, root and CORDIC.
// Two register stages. Depends on cau_pkg.
module cau_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cau_pkg::req_t  req_i,
  output logic           valid_o,
  output cau_pkg::core_t core_o
);
  import cau_pkg::*;

  prod_t prod_d, prod_q;
  core_t core_d, core_q;
  logic  pvalid_q, cvalid_q;

  logic signed [IN_W:0]   sum_re, sum_im;
  logic signed [PROD_W:0] mre, mim, nre, nim, nre_abs, nim_abs;
  logic [PROD_W-1:0]      sq;
  logic signed [CX_W-1:0] x0, y0;

  always_comb begin
    prod_d       = '0;
    prod_d.op    = op_e'(req_i.req_type);
    prod_d.ar    = req_i.a_re;
    prod_d.ai    = req_i.a_im;
    prod_d.br    = req_i.b_re;
    prod_d.bi    = req_i.b_im;
    prod_d.p_rr  = req_i.a_re * req_i.b_re;
    prod_d.p_ii  = req_i.a_im * req_i.b_im;
    prod_d.p_ir  = req_i.a_im * req_i.b_re;
    prod_d.p_ri  = req_i.a_re * req_i.b_im;
    prod_d.p_bbr = req_i.b_re * req_i.b_re;
    prod_d.p_bbi = req_i.b_im * req_i.b_im;
    prod_d.p_aar = req_i.a_re * req_i.a_re;
    prod_d.p_aai = req_i.a_im * req_i.a_im;
  end

  always_comb begin
    core_d = '0;
    core_d.op = prod_q.op;

    if (prod_q.op == OP_SUB) begin
      sum_re = (IN_W+1)'(prod_q.ar) - (IN_W+1)'(prod_q.br);
      sum_im = (IN_W+1)'(prod_q.ai) - (IN_W+1)'(prod_q.bi);
    end else begin
      sum_re = (IN_W+1)'(prod_q.ar) + (IN_W+1)'(prod_q.br);
      sum_im = (IN_W+1)'(prod_q.ai) + (IN_W+1)'(prod_q.bi);
    end
    mre = (PROD_W+1)'(prod_q.p_rr) - (PROD_W+1)'(prod_q.p_ii);
    mim = (PROD_W+1)'(prod_q.p_ir) + (PROD_W+1)'(prod_q.p_ri);
    nre = (PROD_W+1)'(prod_q.p_rr) + (PROD_W+1)'(prod_q.p_ii);
    nim = (PROD_W+1)'(prod_q.p_ir) - (PROD_W+1)'(prod_q.p_ri);
    nre_abs = nre[PROD_W] ? -nre : nre;
    nim_abs = nim[PROD_W] ? -nim : nim;
    sq = PROD_W'(prod_q.p_aar) + PROD_W'(prod_q.p_aai);

    case (prod_q.op)
      OP_ADD, OP_SUB: begin
        core_d.simple_re = OUT_W'(sum_re) <<< (OUT_FRAC - IN_FRAC);
        core_d.simple_im = OUT_W'(sum_im) <<< (OUT_FRAC - IN_FRAC);
      end
      OP_MUL: begin
        core_d.simple_re = OUT_W'(mre) <<< (OUT_FRAC - 2 * IN_FRAC);
        core_d.simple_im = OUT_W'(mim) <<< (OUT_FRAC - 2 * IN_FRAC);
      end
      OP_EQUAL: begin
        core_d.eq = (prod_q.ar == prod_q.br) && (prod_q.ai == prod_q.bi);
      end
      default: begin
        core_d.simple_re = '0;
      end
    endcase

    core_d.den      = PROD_W'(prod_q.p_bbr) + PROD_W'(prod_q.p_bbi);
    core_d.div_zero = (core_d.den == '0);
    core_d.neg_re   = nre[PROD_W];
    core_d.neg_im   = nim[PROD_W];
    core_d.dvd_re   = {nre_abs[PROD_W-1:0], {OUT_FRAC{1'b0}}};
    core_d.dvd_im   = {nim_abs[PROD_W-1:0], {OUT_FRAC{1'b0}}};
    core_d.rad      = {sq, {(SQ_W-PROD_W){1'b0}}};

    // pre-rotation by +-90 degrees for the left half-plane
    x0 = CX_W'(prod_q.ar) <<< 16;
    y0 = CX_W'(prod_q.ai) <<< 16;
    core_d.cx = x0;
    core_d.cy = y0;
    if (prod_q.ar < 0) begin
      if (prod_q.ai >= 0) begin
        core_d.cx  = y0;
        core_d.cy  = -x0;
        core_d.ang = ANG_90;
      end else begin
        core_d.cx  = -y0;
        core_d.cy  = x0;
        core_d.ang = -ANG_90;
      end
    end
    core_d.ang_zero = (prod_q.ar == 0) && (prod_q.ai == 0);
    core_d.ang_neg  = (prod_q.ai == 0) && (prod_q.ar < 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
      cvalid_q <= 1'b0;
    end else if (en_i) begin
      pvalid_q <= valid_i;
      cvalid_q <= pvalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      core_q <= core_d;
    end
  end

  assign valid_o = cvalid_q;
  assign core_o  = core_q;

endmodule

>>> hw/rtl/cau_core.sv
`timescale 1ns / 1ps
// Iterative core: each stage adds a quotient bit per part; stages below ROOT_W also add a root bit
// and stages below CORDIC_STEPS a CORDIC rotation. CORE_STAGES register stages. Depends on cau_pkg.
module cau_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cau_pkg::core_t core_i,
  output logic           valid_o,
  output cau_pkg::core_t core_o
);
  import cau_pkg::*;

  core_t stg_in [CORE_STAGES];
  core_t stg_d  [CORE_STAGES];
  core_t stg_q  [CORE_STAGES];
  logic [CORE_STAGES-1:0] vld_q;

  for (genvar k = 0; k < CORE_STAGES; k++) begin : g_stage
    logic [DEN_W:0]         dt_re, dt_im;
    logic [SREM_W+1:0]      st, strial;
    logic signed [CX_W-1:0] dx, dy;

    if (k == 0) begin : g_first
      assign stg_in[k] = core_i;
    end else begin : g_next
      assign stg_in[k] = stg_q[k-1];
    end

    always_comb begin
      stg_d[k] = stg_in[k];
      st       = '0;
      strial   = '0;
      dx       = '0;
      dy       = '0;

      dt_re = {stg_in[k].rem_re, stg_in[k].dvd_re[DVD_W-1]};
      dt_im = {stg_in[k].rem_im, stg_in[k].dvd_im[DVD_W-1]};
      stg_d[k].dvd_re = stg_in[k].dvd_re << 1;
      stg_d[k].dvd_im = stg_in[k].dvd_im << 1;
      if (dt_re >= {1'b0, stg_in[k].den}) begin
        stg_d[k].rem_re = DEN_W'(dt_re - {1'b0, stg_in[k].den});
        stg_d[k].q_re   = {stg_in[k].q_re[DVD_W-2:0], 1'b1};
      end else begin
        stg_d[k].rem_re = dt_re[DEN_W-1:0];
        stg_d[k].q_re   = {stg_in[k].q_re[DVD_W-2:0], 1'b0};
      end
      if (dt_im >= {1'b0, stg_in[k].den}) begin
        stg_d[k].rem_im = DEN_W'(dt_im - {1'b0, stg_in[k].den});
        stg_d[k].q_im   = {stg_in[k].q_im[DVD_W-2:0], 1'b1};
      end else begin
        stg_d[k].rem_im = dt_im[DEN_W-1:0];
        stg_d[k].q_im   = {stg_in[k].q_im[DVD_W-2:0], 1'b0};
      end

      if (k < ROOT_W) begin
        st     = {stg_in[k].srem, stg_in[k].rad[SQ_W-1 -: 2]};
        strial = (SREM_W+2)'({stg_in[k].root, 2'b01});
        stg_d[k].rad = stg_in[k].rad << 2;
        if (st >= strial) begin
          stg_d[k].srem = SREM_W'(st - strial);
          stg_d[k].root = {stg_in[k].root[ROOT_W-2:0], 1'b1};
        end else begin
          stg_d[k].srem = SREM_W'(st);
          stg_d[k].root = {stg_in[k].root[ROOT_W-2:0], 1'b0};
        end
      end

      if (k < CORDIC_STEPS) begin
        dx = stg_in[k].cy >>> k;
        dy = stg_in[k].cx >>> k;
        if (!stg_in[k].cy[CX_W-1]) begin
          stg_d[k].cx  = stg_in[k].cx + dx;
          stg_d[k].cy  = stg_in[k].cy - dy;
          stg_d[k].ang = stg_in[k].ang + atan_deg(5'(k));
        end else begin
          stg_d[k].cx  = stg_in[k].cx - dx;
          stg_d[k].cy  = stg_in[k].cy + dy;
          stg_d[k].ang = stg_in[k].ang - atan_deg(5'(k));
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CORE_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[CORE_STAGES-1];
  assign core_o  = stg_q[CORE_STAGES-1];

endmodule

>>> hw/rtl/cau_back.sv
`timescale 1ns / 1ps
// Back end: result selection, quotient sign and saturation, angle rounding, output register.
// Depends on cau_pkg.
module cau_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cau_pkg::core_t core_i,
  output logic           valid_o,
  output cau_pkg::res_t  res_o
);
  import cau_pkg::*;

  res_t res_d, res_q;
  logic valid_q;
  logic sat;
  logic signed [ANG_W-1:0] ang_c, ang_r;

  function automatic logic signed [OUT_W-1:0] fit_q(input logic [DVD_W-1:0] q,
                                                    input logic neg);
    logic signed [OUT_W-1:0] v;
    if (!neg && q > Q_POS_LIM) begin
      v = OUT_MAX;
    end else if (neg && q > Q_POS_LIM + DVD_W'(1)) begin
      v = OUT_MIN;
    end else begin
      v = neg ? -OUT_W'(q) : OUT_W'(q);
    end
    return v;
  endfunction

  always_comb begin
    res_d = '0;
    sat   = 1'b0;
    ang_c = core_i.ang;
    if (core_i.ang > ANG_180) begin
      ang_c = ANG_180;
    end else if (core_i.ang < -ANG_180) begin
      ang_c = -ANG_180;
    end
    ang_r = (ang_c + ANG_HALF) >>> ANG_RND;

    case (core_i.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        res_d.res_re = core_i.simple_re;
        res_d.res_im = core_i.simple_im;
      end
      OP_DIV: begin
        if (core_i.div_zero) begin
          res_d.status = ST_DIVZERO;
        end else begin
          res_d.res_re = fit_q(core_i.q_re, core_i.neg_re);
          res_d.res_im = fit_q(core_i.q_im, core_i.neg_im);
          sat = (core_i.q_re > Q_POS_LIM + DVD_W'(core_i.neg_re)) ||
                (core_i.q_im > Q_POS_LIM + DVD_W'(core_i.neg_im));
          if (sat) begin
            res_d.status = ST_SAT;
          end
        end
      end
      OP_MAG: begin
        res_d.res_re = OUT_W'(core_i.root);
      end
      OP_ANGLE: begin
        if (core_i.ang_zero) begin
          res_d.res_re = '0;
        end else if (core_i.ang_neg) begin
          res_d.res_re = OUT_180;
        end else begin
          res_d.res_re = OUT_W'(ang_r);
        end
      end
      OP_EQUAL: begin
        res_d.is_equal = core_i.eq;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hw/rtl/complex_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// Complex arithmetic unit, top level. Depends on cau_pkg, cau_front, cau_core, cau_back.
// Path from request to result: the front stages, then the core stages, then the output register.
// Throughput: one request per cycle while the output is not stalled; the 48-stage long-division chain sets the depth.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears all valid bits; data registers are not reset.
module complex_arithmetic_unit_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cau_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cau_pkg::res_t out_res_o
);
  import cau_pkg::*;

  logic  adv;
  logic  front_valid, core_valid;
  core_t front_core, core_out;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (front_valid),
    .core_o  (front_core)
  );

  cau_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (front_valid),
    .core_i  (front_core),
    .valid_o (core_valid),
    .core_o  (core_out)
  );

  cau_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (core_valid),
    .core_i  (core_out),
    .valid_o (out_valid_o),
    .res_o   (out_res_o)
  );

`ifndef SYNTHESIS
  a_divzero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status == ST_DIVZERO |->
      out_res_o.res_re == '0 && out_res_o.res_im == '0)
    else $error("divide by zero with non-zero result");

  a_equal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.is_equal |->
      out_res_o.res_re == '0 && out_res_o.res_im == '0 && out_res_o.status == ST_OK)
    else $error("equal flag with stray result");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status == ST_SAT |->
      out_res_o.res_re == OUT_MAX || out_res_o.res_re == OUT_MIN ||
      out_res_o.res_im == OUT_MAX || out_res_o.res_im == OUT_MIN)
    else $error("saturation status without a clamped part");
`endif

endmodule
